// ----- rtl/core/tfn_pkg.sv -----
package tfn_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 14;

   // tolerance register
   localparam int          TOL_WIDTH = 32;
   localparam logic [31:0] TOL_RESET = 32'd268;

   // block-scaled magnitudes are kept below 2^NORM_BITS
   localparam int NORM_BITS = 30;

endpackage

// ----- rtl/core/triangle_face_normal.sv -----
// Channel   Dir  Beat contents (low bits first)
// -------   ---  -------------------------------------------------------------
// req_      in   tdata: ax ay az bx by_coord bz cx cy cz (COORD_WIDTH each)
// rsp_      out  tdata: nx ny nz (COORD_WIDTH each), tuser: degenerate
// csr_      in   wr_en / wr_data: zero_tolerance, no read-back
//
// One beat accepted per clock when the pipe is flowing; the pipe holds
// the 32-step square root and the FRAC_BITS+1 step dividers,
// each one stage per step.
// Every stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles collapse and rsp_tready low stalls only the
// occupied tail. reset (synchronous) clears all valid bits and loads the
// tolerance reset value; no clearing pass.
module triangle_face_normal
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int IN_TW  = ((9 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [TOL_WIDTH-1:0]  csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_TW-1:0]      req_tdata,   // ax ay az bx by_coord bz cx cy cz
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_TW-1:0]     rsp_tdata,   // nx ny nz
   output logic                  rsp_tuser    // degenerate
);

   localparam int CW   = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int EW   = CW + 1;               // edge component
   localparam int PW   = 2 * EW;               // edge product
   localparam int CRW  = PW + 1;               // cross component
   localparam int KW   = $clog2(CRW + 1);
   localparam int RW   = NORM_BITS;
   localparam int LENW = $clog2(RW + 1);
   localparam int SQW  = 2 * RW;
   localparam int SW   = SQW + 2;              // sum of three squares
   localparam int RTN  = SW / 2 + 1;           // root steps
   localparam int RTW  = SW + 2;
   localparam int LW   = RW + 1;               // root width
   localparam int DW   = LW + F + 1;           // divider remainder
   localparam int QW   = F + 1;                // quotient
   localparam int SHW  = $clog2(2 * F + 1);
   localparam int CMPW = (TOL_WIDTH + 2 * F > SW) ? TOL_WIDTH + 2 * F : SW;
   localparam int SATW = (QW > CW) ? QW : CW;

   // stage map
   localparam int S_ED  = 0;
   localparam int S_PR  = 1;
   localparam int S_CR  = 2;
   localparam int S_K   = 3;
   localparam int S_R   = 4;
   localparam int S_SQ  = 5;
   localparam int S_SUM = 6;
   localparam int S_DEG = 7;
   localparam int S_RN  = 8;
   localparam int S_SQ2 = 9;
   localparam int S_SM2 = 10;
   localparam int S_RT0 = 11;
   localparam int S_DI  = S_RT0 + RTN;
   localparam int S_DV0 = S_DI + 1;
   localparam int S_OUT = S_DV0 + QW;
   localparam int NS    = S_OUT + 1;

   typedef logic signed [EW-1:0]  edge_type;
   typedef logic signed [PW-1:0]  prod_type;
   typedef logic        [CRW-1:0] mag_type;
   typedef logic        [RW-1:0]  norm_type;
   typedef logic        [SQW-1:0] sq_type;
   typedef logic        [DW-1:0]  rem_type;
   typedef logic        [QW-1:0]  quo_type;

   // ---------------- control ----------------
   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_tvalid;
         for (int i = 1; i < NS; i++) begin
            if (en[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   logic [TOL_WIDTH-1:0] tol_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // side data that rides along the pipe
   logic [2:0]     neg_ff [NS];
   logic           deg_ff [NS];
   norm_type       rn_ff  [NS][3];
   logic [KW-1:0]  k_ff   [NS];

   // ---------------- stage datapath ----------------
   edge_type       e1_ff [3];
   edge_type       e2_ff [3];
   prod_type       p_ff  [6];
   mag_type        mag_ff [3];
   mag_type        mag3_ff [3];
   sq_type         sq_ff [3];
   logic [SW-1:0]  sum_ff;
   logic [LENW-1:0] sh_ff;
   sq_type         sq2_ff [3];
   logic [RTW-1:0] rv_ff [RTN];
   logic [RTW-1:0] rs_ff [RTN];
   logic [LW-1:0]  len_ff [QW+1];
   rem_type        rem_ff [QW+1][3];
   quo_type        q_ff   [QW+1][3];
   logic [CW-1:0]  n_ff [3];

   // second sum feeds the root chain
   logic [SW-1:0]  sum_ff_2;
   logic [RTW-1:0] rt_src;
   assign rt_src = RTW'(sum_ff_2);

   // edges
   logic signed [CW-1:0] vin [9];
   edge_type e1_in [3];
   edge_type e2_in [3];
   always_comb begin
      for (int i = 0; i < 9; i++) vin[i] = req_tdata[i*CW +: CW];
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = EW'(vin[3+i]) - EW'(vin[i]);
         e2_in[i] = EW'(vin[6+i]) - EW'(vin[3+i]);
      end
   end

   // cross product and magnitudes
   logic signed [CRW-1:0] cr_in [3];
   mag_type  mag_in [3];
   logic [2:0] neg_in;
   always_comb begin
      cr_in[0] = CRW'(p_ff[0]) - CRW'(p_ff[1]);
      cr_in[1] = CRW'(p_ff[2]) - CRW'(p_ff[3]);
      cr_in[2] = CRW'(p_ff[4]) - CRW'(p_ff[5]);
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = cr_in[i][CRW-1];
         mag_in[i] = neg_in[i] ? mag_type'(-cr_in[i]) : mag_type'(cr_in[i]);
      end
   end

   // block-scaling shift k
   mag_type       mor;
   logic [KW-1:0] blen;
   logic [KW-1:0] k_in;
   always_comb begin
      mor  = mag_ff[0] | mag_ff[1] | mag_ff[2];
      blen = '0;
      for (int j = 0; j < CRW; j++) begin
         if (mor[j]) blen = KW'(j + 1);
      end
      k_in = (blen > KW'(RW)) ? blen - KW'(RW) : '0;
   end

   norm_type r_in [3];
   always_comb begin
      for (int i = 0; i < 3; i++) r_in[i] = norm_type'(mag3_ff[i] >> k_ff[S_K]);
   end

   // degenerate test and normalizing shift
   logic [CMPW-1:0] thr;
   logic [SHW-1:0]  shamt;
   logic            deg_in;
   norm_type        ror;
   logic [LENW-1:0] mlen;
   logic [LENW-1:0] sh_in;
   always_comb begin
      shamt  = '0;
      thr    = '0;
      deg_in = (sum_ff == '0);
      if (k_ff[S_SUM] <= KW'(F)) begin
         shamt  = SHW'(2 * (F - int'(k_ff[S_SUM])));
         thr    = CMPW'(tol_ff) << shamt;
         deg_in = CMPW'(sum_ff) <= thr;
      end
      ror  = rn_ff[S_SUM][0] | rn_ff[S_SUM][1] | rn_ff[S_SUM][2];
      mlen = '0;
      for (int j = 0; j < RW; j++) begin
         if (ror[j]) mlen = LENW'(j + 1);
      end
      sh_in = LENW'(RW) - mlen;
   end

   // square root, one result bit per stage
   logic [RTW-1:0] rv_in [RTN];
   logic [RTW-1:0] rs_in [RTN];
   always_comb begin
      logic [RTW-1:0] v;
      logic [RTW-1:0] rs;
      logic [RTW-1:0] bitv;
      logic [RTW-1:0] t;
      for (int i = 0; i < RTN; i++) begin
         v    = (i == 0) ? rt_src : rv_ff[(i == 0) ? 0 : i-1];
         rs   = (i == 0) ? '0 : rs_ff[(i == 0) ? 0 : i-1];
         bitv = RTW'(1) << (SW - 2 * i);
         t    = rs + bitv;
         if (v >= t) begin
            rv_in[i] = v - t;
            rs_in[i] = (rs >> 1) + bitv;
         end else begin
            rv_in[i] = v;
            rs_in[i] = rs >> 1;
         end
      end
   end

   // restoring dividers, one quotient bit per stage
   logic [LW-1:0] root;
   rem_type rem0_in [3];
   rem_type rem_in [QW][3];
   quo_type q_in   [QW][3];
   always_comb begin
      rem_type sub;
      root = LW'(rs_ff[RTN-1]);
      for (int c = 0; c < 3; c++) begin
         rem0_in[c] = (rem_type'(rn_ff[S_DI-1][c]) << F) + rem_type'(root >> 1);
      end
      for (int t = 0; t < QW; t++) begin
         sub = rem_type'(len_ff[t]) << (F - t);
         for (int c = 0; c < 3; c++) begin
            rem_in[t][c] = rem_ff[t][c];
            q_in[t][c]   = q_ff[t][c];
            if (rem_ff[t][c] >= sub) begin
               rem_in[t][c]      = rem_ff[t][c] - sub;
               q_in[t][c][F - t] = 1'b1;
            end
         end
      end
   end

   // saturate and restore sign
   logic [CW-1:0] omax;
   logic [CW-1:0] msat [3];
   logic [CW-1:0] n_in [3];
   always_comb begin
      omax = {1'b0, {(CW-1){1'b1}}};
      for (int c = 0; c < 3; c++) begin
         msat[c] = (SATW'(q_ff[QW][c]) > SATW'(omax)) ? omax : CW'(q_ff[QW][c]);
         n_in[c] = deg_ff[S_OUT-1] ? '0
                 : (neg_ff[S_OUT-1][c] ? CW'(-msat[c]) : msat[c]);
      end
   end

   always_ff @(posedge clock) begin
      // carry of side data past the stage that produces it
      for (int i = 1; i < NS; i++) begin
         if (en[i]) begin
            if (i > S_CR)  neg_ff[i] <= neg_ff[i-1];
            if (i > S_DEG) deg_ff[i] <= deg_ff[i-1];
            if (i > S_K)   k_ff[i]   <= k_ff[i-1];
            if (i > S_R && i != S_RN) begin
               for (int c = 0; c < 3; c++) rn_ff[i][c] <= rn_ff[i-1][c];
            end
         end
      end
      if (en[S_ED]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
      if (en[S_PR]) begin
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
      end
      if (en[S_CR]) begin
         mag_ff        <= mag_in;
         neg_ff[S_CR]  <= neg_in;
      end
      if (en[S_K]) begin
         mag3_ff   <= mag_ff;
         k_ff[S_K] <= k_in;
      end
      if (en[S_R]) begin
         for (int c = 0; c < 3; c++) rn_ff[S_R][c] <= r_in[c];
      end
      if (en[S_SQ]) begin
         for (int c = 0; c < 3; c++) sq_ff[c] <= rn_ff[S_R][c] * rn_ff[S_R][c];
      end
      if (en[S_SUM]) begin
         sum_ff <= SW'(sq_ff[0]) + SW'(sq_ff[1]) + SW'(sq_ff[2]);
      end
      if (en[S_DEG]) begin
         deg_ff[S_DEG] <= deg_in;
         sh_ff         <= sh_in;
      end
      if (en[S_RN]) begin
         for (int c = 0; c < 3; c++) rn_ff[S_RN][c] <= rn_ff[S_DEG][c] << sh_ff;
      end
      if (en[S_SQ2]) begin
         for (int c = 0; c < 3; c++) sq2_ff[c] <= rn_ff[S_RN][c] * rn_ff[S_RN][c];
      end
      if (en[S_SM2]) begin
         sum_ff_2 <= SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);
      end
      for (int i = 0; i < RTN; i++) begin
         if (en[S_RT0 + i]) begin
            rv_ff[i] <= rv_in[i];
            rs_ff[i] <= rs_in[i];
         end
      end
      if (en[S_DI]) begin
         len_ff[0] <= root;
         for (int c = 0; c < 3; c++) begin
            rem_ff[0][c] <= rem0_in[c];
            q_ff[0][c]   <= '0;
         end
      end
      for (int t = 0; t < QW; t++) begin
         if (en[S_DV0 + t]) begin
            len_ff[t+1] <= len_ff[t];
            for (int c = 0; c < 3; c++) begin
               rem_ff[t+1][c] <= rem_in[t][c];
               q_ff[t+1][c]   <= q_in[t][c];
            end
         end
      end
      if (en[S_OUT]) begin
         n_ff <= n_in;
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int c = 0; c < 3; c++) rsp_tdata[c*CW +: CW] = n_ff[c];
   end
   assign rsp_tuser = deg_ff[S_OUT];

endmodule

// ----- rtl/core/tfn_checker.sv -----
module tfn_checker
   import tfn_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   localparam int IN_TW  = ((9 * COORD_WIDTH + 7) / 8) * 8,
   localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_wr_en,
   input logic [TOL_WIDTH-1:0] csr_wr_data,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [IN_TW-1:0]     req_tdata,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [OUT_TW-1:0]    rsp_tdata,
   input logic                 rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed under stall");

   // degenerate beats carry the zero vector
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("degenerate beat with nonzero normal");

   // a unit normal never comes out all zero
   a_unit_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != '0)
      else $error("unit normal is zero");

   // pipe is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind triangle_face_normal tfn_checker #(
   .COORD_WIDTH (COORD_WIDTH),
   .FRAC_BITS   (FRAC_BITS)
) u_tfn_checker (.*);
